// File: hdl/tbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tent blur row filter package
// Shared widths, beat types and controller command/status bundles.
// ----------------------------------------------------------------------------
package tbr_pkg;

   localparam int MAX_RADIUS   = 31;
   localparam int POS_CAP      = 2 * MAX_RADIUS;
   localparam int POS_W        = $clog2(POS_CAP + 1);
   localparam int RAD_W        = $clog2(MAX_RADIUS + 1);
   localparam int WT_W         = RAD_W + 1;
   localparam int ADDR_W       = $clog2(2 * MAX_RADIUS + 1);
   localparam int MEM_DEPTH    = 2 ** ADDR_W;
   localparam int K_W          = POS_W + 2;
   localparam int W_W          = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int ACC_W        = W_W + CHAN_W;
   localparam int FRAC_BITS    = 24;
   localparam int Q_W          = FRAC_BITS + 1;
   localparam int QCNT_W       = $clog2(FRAC_BITS + 1);
   localparam int PROD_W       = ACC_W + Q_W;
   localparam int CSR_W        = 5;

   localparam logic [CSR_W-1:0]  RADIUS_RESET = CSR_W'(1);
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic              row_last;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
      logic              row_done;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic lag_load;
      logic lag_dec;
      logic sum_clear;
      logic tap_issue;
      logic div_start;
      logic mul_load;
      logic out_load;
      logic row_clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic has_output;
      logic tap_final;
      logic div_done;
      logic out_free;
      logic run_last;
      logic row_last;
   } ctrl_sts_type;

   // Clamp the programmed radius to the largest supported one.
   function automatic logic [RAD_W-1:0] sat_radius(input logic [CSR_W-1:0] value);
      logic [RAD_W-1:0] res;
      if (int'(value) > MAX_RADIUS) begin
         res = RAD_W'(MAX_RADIUS);
      end else begin
         res = RAD_W'(value);
      end
      return res;
   endfunction

endpackage

// File: hdl/tent_blur_row_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tent blur row filter
// One-dimensional triangular blur over a row of RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Feed one pixel per req beat; mark the final pixel of a row with row_last.
//  - Each pixel at row position p >= radius yields one rsp beat for pixel
//    p - radius; a row_last pixel flushes min(p, radius) + 1 beats, the last
//    of which carries row_done. run_last marks the final beat of each request.
//  - Each result takes a sweep of 2*radius + 1 taps through the single window
//    read port, then a 25-step bit-serial reciprocal of the total weight and
//    one scaling multiply. A request also passes through accept and decode on
//    top of its results; a request that gives no result ends after decode.
//  - One request is in flight at a time; req_stall is low only when idle. The
//    result register lets the block go back to idle while the last beat
//    still waits, so a stalled receiver only holds up the next result.
//  - csr_write_data sets the radius (reset value 1); write it only when idle.
//  - Synchronous reset clears the row state and drops any pending beat.
// ----------------------------------------------------------------------------
module tent_blur_row_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tbr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tbr_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_en,
   input  logic [tbr_pkg::CSR_W-1:0]  csr_write_data
);
   import tbr_pkg::*;

   // Command and status between the sequencer and the datapath
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // Sequencer: one request at a time, one result at a time
   tbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Window, weighted sums, reciprocal scaling and result register
   tbr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .sts            (sts)
   );

   // Never overwrite a beat that is still waiting to be taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A request in flight blocks the next one.
   a_single_item : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted while busy");

   // The final beat of a row is also the final beat of its request.
   a_row_done_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.row_done) |-> rsp_data.run_last)
      else $error("row_done without run_last");

endmodule

// File: hdl/tbr_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tent blur reciprocal unit
// Bit-serial restoring divide: quotient = floor(2^FRAC_BITS / divisor).
// ----------------------------------------------------------------------------
module tbr_recip (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [tbr_pkg::W_W-1:0] divisor,
   output logic [tbr_pkg::Q_W-1:0] quotient,
   output logic                  done
);
   import tbr_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [W_W-1:0]    rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [W_W:0]      trial;
   logic              fits;

   // The dividend is a single one at bit FRAC_BITS; feed it on the first step.
   assign trial = {rem_ff, (cnt_ff == QCNT_W'(FRAC_BITS))};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = QCNT_W'(FRAC_BITS);
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? W_W'(trial - {1'b0, divisor}) : W_W'(trial);
         quo_in = {quo_ff[Q_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: hdl/tbr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tent blur controller
// Sequences accept, tap sweep, reciprocal, scale and emit for each result.
// ----------------------------------------------------------------------------
module tbr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tbr_pkg::ctrl_sts_type sts,
   output tbr_pkg::ctrl_cmd_type cmd
);
   import tbr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_SUM,
      ST_DRAIN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (sts.has_output) begin
               cmd.lag_load  = 1'b1;
               cmd.sum_clear = 1'b1;
               state_in      = ST_SUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            cmd.tap_issue = 1'b1;
            if (sts.tap_final) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.run_last) begin
                  cmd.row_clear = sts.row_last;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.lag_dec   = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = ST_SUM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/tbr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tent blur datapath
// Pixel window memory, tap weighting, accumulators, scaling and output beat.
// ----------------------------------------------------------------------------
module tbr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  tbr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tbr_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_en,
   input  logic [tbr_pkg::CSR_W-1:0]  csr_write_data,
   input  tbr_pkg::ctrl_cmd_type      cmd,
   output tbr_pkg::ctrl_sts_type      sts
);
   import tbr_pkg::*;

   // Configuration and per-item context
   logic [CSR_W-1:0]  radius_ff, radius_in;
   logic [RAD_W-1:0]  r_ff;
   logic              last_ff;

   // Row tracking
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              started_ff, started_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;

   // Window memory
   logic [PIX_W-1:0]  win_mem [MEM_DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   // Tap sweep
   logic [RAD_W-1:0]      lag_ff, lag_in;
   logic [POS_W-1:0]      tap_ff, tap_in;
   logic signed [K_W-1:0] age;
   logic                  tap_valid;
   logic [POS_W-1:0]      r_ext;
   logic [POS_W-1:0]      tap_off;
   logic [WT_W-1:0]       wt;
   logic [WT_W-1:0]       wt_ff;
   logic                  acc_en_ff, acc_en_in;

   // Accumulators and scaling
   logic [ACC_W-1:0]  acc_r_ff, acc_g_ff, acc_b_ff;
   logic [ACC_W-1:0]  acc_r_in, acc_g_in, acc_b_in;
   logic [W_W-1:0]    wsum_ff, wsum_in;
   logic [Q_W-1:0]    recip;
   logic              div_done;
   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   logic              lag_zero;

   tbr_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (wsum_ff),
      .quotient (recip),
      .done     (div_done)
   );

   assign lag_zero = (lag_ff == '0);
   assign r_ext    = POS_W'(r_ff);

   // Age of the tap pixel behind the newest one: lag + radius - tap.
   assign age       = $signed(K_W'(lag_ff) + K_W'(r_ff) - K_W'(tap_ff));
   assign tap_valid = !age[K_W-1] && (age[K_W-2:0] <= (K_W-1)'(pos_ff));
   assign rd_addr   = wp_ff - ADDR_W'(1) - age[ADDR_W-1:0];
   assign tap_off   = (tap_ff >= r_ext) ? (tap_ff - r_ext) : (r_ext - tap_ff);
   assign wt        = WT_W'(r_ff) + WT_W'(1) - WT_W'(tap_off);

   always_comb begin
      radius_in  = csr_write_en ? csr_write_data : radius_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      wp_in      = wp_ff;
      if (cmd.accept) begin
         wp_in = wp_ff + ADDR_W'(1);
         if (!started_ff) begin
            started_in = 1'b1;
         end else if (pos_ff < POS_W'(POS_CAP)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      if (cmd.row_clear) begin
         pos_in     = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         pos_ff     <= '0;
         started_ff <= 1'b0;
         wp_ff      <= '0;
      end else begin
         radius_ff  <= radius_in;
         pos_ff     <= pos_in;
         started_ff <= started_in;
         wp_ff      <= wp_in;
      end
   end

   // Latch the item context on accept.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         r_ff    <= sat_radius(radius_ff);
         last_ff <= req_data.row_last;
      end
   end

   // Window: write the new pixel on accept, read one tap per cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         win_mem[wp_ff] <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= win_mem[rd_addr];
   end

   always_comb begin
      lag_in = lag_ff;
      tap_in = tap_ff;
      if (cmd.lag_load) begin
         lag_in = last_ff ? ((pos_ff < r_ext) ? RAD_W'(pos_ff) : r_ff) : r_ff;
      end else if (cmd.lag_dec) begin
         lag_in = lag_ff - RAD_W'(1);
      end
      if (cmd.sum_clear) begin
         tap_in = '0;
      end else if (cmd.tap_issue) begin
         tap_in = tap_ff + POS_W'(1);
      end
      acc_en_in = cmd.tap_issue && tap_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= acc_en_in;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff <= lag_in;
      tap_ff <= tap_in;
      wt_ff  <= wt;
   end

   // Weighted sums, one tap a cycle, in the cycle after the read.
   always_comb begin
      acc_r_in = acc_r_ff;
      acc_g_in = acc_g_ff;
      acc_b_in = acc_b_ff;
      wsum_in  = wsum_ff;
      if (cmd.sum_clear) begin
         acc_r_in = '0;
         acc_g_in = '0;
         acc_b_in = '0;
         wsum_in  = '0;
      end else if (acc_en_ff) begin
         acc_r_in = acc_r_ff + ACC_W'(wt_ff) * ACC_W'(rd_data_ff[2*CHAN_W +: CHAN_W]);
         acc_g_in = acc_g_ff + ACC_W'(wt_ff) * ACC_W'(rd_data_ff[CHAN_W +: CHAN_W]);
         acc_b_in = acc_b_ff + ACC_W'(wt_ff) * ACC_W'(rd_data_ff[0 +: CHAN_W]);
         wsum_in  = wsum_ff + W_W'(wt_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_r_ff <= acc_r_in;
      acc_g_ff <= acc_g_in;
      acc_b_ff <= acc_b_in;
      wsum_ff  <= wsum_in;
   end

   // Scale by the reciprocal of the total weight.
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_r_ff <= PROD_W'(acc_r_ff) * PROD_W'(recip);
         prod_g_ff <= PROD_W'(acc_g_ff) * PROD_W'(recip);
         prod_b_ff <= PROD_W'(acc_b_ff) * PROD_W'(recip);
      end
   end

   // Output register: hold while stalled, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.red_out   <= prod_r_ff[FRAC_BITS +: CHAN_W];
         rsp_data_ff.green_out <= prod_g_ff[FRAC_BITS +: CHAN_W];
         rsp_data_ff.blue_out  <= prod_b_ff[FRAC_BITS +: CHAN_W];
         rsp_data_ff.alpha_out <= ALPHA_OPAQUE;
         rsp_data_ff.row_done  <= last_ff && lag_zero;
         rsp_data_ff.run_last  <= !last_ff || lag_zero;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sts.has_output = last_ff || (pos_ff >= r_ext);
      sts.tap_final  = (tap_ff == POS_W'({r_ff, 1'b0}));
      sts.div_done   = div_done;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.run_last   = !last_ff || lag_zero;
      sts.row_last   = last_ff;
   end

endmodule
